// ----- sv/bwrl_pkg.sv -----
// Shared types, constants and register indexes for the burst window byte rate limiter.
package bwrl_pkg;

   // Field widths.
   localparam int TIME_BITS    = 48;
   localparam int LEN_BITS     = 10;
   localparam int BYTES_BITS   = 17;
   localparam int BASE_BITS    = 14;
   localparam int WINLEN_BITS  = 26;
   localparam int CSR_IDX_BITS = 2;

   // Length limit and count saturation.
   localparam logic [LEN_BITS-1:0]   MAX_DATAGRAM = LEN_BITS'(512);
   localparam logic [BYTES_BITS:0]   BYTES_MAX    = {1'b0, {BYTES_BITS{1'b1}}};

   // Register reset values.
   localparam logic [BASE_BITS-1:0]   BASE_LIMIT_RESET = BASE_BITS'(511);
   localparam logic [BYTES_BITS-1:0]  PEAK_LIMIT_RESET = BYTES_BITS'(2048);
   localparam logic [WINLEN_BITS-1:0] WINDOW_LEN_RESET = WINLEN_BITS'(10000000);

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PEAK_LIMIT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LEN = 2'd2;

   // Event codes reported with each result.
   typedef enum logic [2:0] {
      EV_NONE            = 3'd0,
      EV_OVER_PEAK       = 3'd1,
      EV_BASE_AFTER_PEAK = 3'd2,
      EV_NEW_PEAK        = 3'd3,
      EV_ROLLOVER        = 3'd4
   } event_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]  datagram_length;
      logic [TIME_BITS-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [WINLEN_BITS-1:0] hold_off_us;
      event_type              event_res;
      logic [BYTES_BITS-1:0]  window_bytes_out;
   } rsp_type;

   typedef struct packed {
      logic [BASE_BITS-1:0]   base_limit_bytes;
      logic [BYTES_BITS-1:0]  peak_limit_bytes;
      logic [WINLEN_BITS-1:0] window_length_us;
   } cfg_type;

   typedef struct packed {
      logic [BYTES_BITS-1:0] window_bytes;
      logic [TIME_BITS-1:0]  window_start;
      logic                  prior_was_peak;
   } win_state_type;

endpackage

// ----- sv/bwrl_csr.sv -----
// Configuration registers of the rate limiter.
module bwrl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bwrl_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bwrl_pkg::WINLEN_BITS-1:0]    csr_wdata,
   output bwrl_pkg::cfg_type                   cfg
);
   import bwrl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; other indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_LIMIT: cfg_in.base_limit_bytes = csr_wdata[BASE_BITS-1:0];
            CSR_PEAK_LIMIT: cfg_in.peak_limit_bytes = csr_wdata[BYTES_BITS-1:0];
            CSR_WINDOW_LEN: cfg_in.window_length_us = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_limit_bytes <= BASE_LIMIT_RESET;
         cfg_ff.peak_limit_bytes <= PEAK_LIMIT_RESET;
         cfg_ff.window_length_us <= WINDOW_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/bwrl_step.sv -----
// Window accounting for one request: next window state and the result.
module bwrl_step (
   input  bwrl_pkg::cfg_type        cfg,
   input  bwrl_pkg::win_state_type  cur,
   input  bwrl_pkg::req_type        req,
   output bwrl_pkg::win_state_type  nxt,
   output bwrl_pkg::rsp_type        rsp
);
   import bwrl_pkg::*;

   logic [TIME_BITS-1:0]   diff;
   logic [TIME_BITS-1:0]   elapsed;
   logic [TIME_BITS-1:0]   wl_wide;
   logic                   over;
   logic [WINLEN_BITS-1:0] rest;
   logic [LEN_BITS-1:0]    len_clip;
   logic [BYTES_BITS:0]    sum;
   logic [BYTES_BITS-1:0]  sum_sat;
   logic [TIME_BITS-1:0]   hold_start;

   // Time into the window; a start that lies ahead counts as no time gone.
   always_comb begin
      diff     = req.now_us - cur.window_start;
      elapsed  = diff[TIME_BITS-1] ? '0 : diff;
      wl_wide  = {{(TIME_BITS-WINLEN_BITS){1'b0}}, cfg.window_length_us};
      over     = elapsed > wl_wide;
      rest     = (elapsed < wl_wide) ?
                 (cfg.window_length_us - elapsed[WINLEN_BITS-1:0]) : '0;
      hold_start = req.now_us + {{(TIME_BITS-WINLEN_BITS){1'b0}}, rest};
   end

   // Clipped length added to the window count, saturated to the count width.
   always_comb begin
      len_clip = (req.datagram_length > MAX_DATAGRAM) ? MAX_DATAGRAM : req.datagram_length;
      sum      = {1'b0, cur.window_bytes} + {{(BYTES_BITS+1-LEN_BITS){1'b0}}, len_clip};
      sum_sat  = (sum > BYTES_MAX) ? BYTES_MAX[BYTES_BITS-1:0] : sum[BYTES_BITS-1:0];
   end

   // Classify the window against the peak limit first, then the base limit.
   always_comb begin
      nxt             = cur;
      rsp.hold_off_us = '0;
      rsp.event_res   = EV_NONE;
      if (req.datagram_length != '0) begin
         if (sum > {1'b0, cfg.peak_limit_bytes}) begin
            rsp.event_res      = EV_OVER_PEAK;
            rsp.hold_off_us    = rest;
            nxt.window_bytes   = '0;
            nxt.window_start   = hold_start;
            nxt.prior_was_peak = 1'b1;
         end else if (sum > {{(BYTES_BITS+1-BASE_BITS){1'b0}}, cfg.base_limit_bytes}) begin
            if (over) begin
               rsp.event_res      = EV_ROLLOVER;
               nxt.window_bytes   = '0;
               nxt.window_start   = req.now_us;
               nxt.prior_was_peak = 1'b1;
            end else if (cur.prior_was_peak) begin
               rsp.event_res      = EV_BASE_AFTER_PEAK;
               rsp.hold_off_us    = rest;
               nxt.window_bytes   = '0;
               nxt.window_start   = hold_start;
               nxt.prior_was_peak = 1'b1;
            end else begin
               rsp.event_res    = EV_NEW_PEAK;
               nxt.window_bytes = sum_sat;
            end
         end else if (over) begin
            rsp.event_res      = EV_ROLLOVER;
            nxt.window_bytes   = '0;
            nxt.window_start   = req.now_us;
            nxt.prior_was_peak = 1'b0;
         end else begin
            nxt.window_bytes = sum_sat;
         end
      end
      rsp.window_bytes_out = nxt.window_bytes;
   end

endmodule

// ----- sv/burst_window_byte_rate_limiter_top.sv -----
// Top level of the burst window byte rate limiter: request and result registers, window state.
// Path: a request is captured in the input register, and its result in the result register.
// Throughput: one request per cycle while the result is not stalled; the window state updates
// in the same cycle the request moves from the input register to the result register.
// Reset: clears both valid flags and the window state, and loads the register defaults
// (base limit 511, peak limit 2048, window length 10000000 us).
module burst_window_byte_rate_limiter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bwrl_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bwrl_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [bwrl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bwrl_pkg::WINLEN_BITS-1:0]   csr_wdata
);
   import bwrl_pkg::*;

   cfg_type       cfg;
   logic          in_valid_ff;
   req_type       in_req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   win_state_type win_state_ff;
   win_state_type win_state_in;
   rsp_type       step_rsp;
   logic          advance;

   bwrl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bwrl_step u_step (
      .cfg (cfg),
      .cur (win_state_ff),
      .req (in_req_ff),
      .nxt (win_state_in),
      .rsp (step_rsp)
   );

   // The held request moves on whenever the result register is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_req_ff <= req_data;
      end
   end

   // Result register and window state, updated as the request is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         win_state_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            win_state_ff <= win_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
